### rtl/core/htld_pkg.sv
// Shared constants, types and codes of the hotness table.
`default_nettype none

package htld_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  localparam int KEY_W      = 10;
  localparam int NODE_W     = 3;
  localparam int TIME_W     = 16;
  localparam int HOT_W      = 8;
  localparam int STAB_W     = 8;
  localparam int HITS_W     = 32;
  localparam int PREF_W     = 4;
  localparam int DECAY_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [HOT_W-1:0]  HEAT_CEIL    = HOT_W'(15);
  localparam logic [HOT_W-1:0]  HOTNESS_MIN  = HOT_W'(0);
  localparam logic [PREF_W-1:0] NO_PREFERRED = PREF_W'(15);
  localparam logic [HITS_W-1:0] HITS_FULL    = '1;

  typedef enum logic {
    REQ_ACCESS = 1'b0,
    REQ_SWEEP  = 1'b1
  } req_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIG_LEVEL         = 3'd0,
    CFG_IDLE_DECAY_SECS   = 3'd1,
    CFG_STABILITY_LIMIT   = 3'd2,
    CFG_LAZY_STEP1_SECS   = 3'd3,
    CFG_LAZY_STEP2_SECS   = 3'd4,
    CFG_LAZY_STEP3_SECS   = 3'd5,
    CFG_LAZY_STEP4_SECS   = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [HOT_W-1:0]  hotness;
    logic [STAB_W-1:0] stability;
    logic [TIME_W-1:0] last_seen;
    logic [HITS_W-1:0] hits;
    logic [NODE_W-1:0] home_node;
    logic [PREF_W-1:0] preferred;
  } entry_t;

  typedef struct packed {
    logic [KEY_W-1:0]   entry_index;
    logic [HOT_W-1:0]   hotness_after;
    logic               new_entry;
    logic               migrate_candidate;
    logic [NODE_W-1:0]  dest_node;
    logic [DECAY_W-1:0] decays_done;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/core/htld_if.sv
// Handshake interfaces for the request, response and configuration channels.
`default_nettype none

interface htld_req_if import htld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [KEY_W-1:0]  key_index;
  logic [NODE_W-1:0] requester_node;
  logic [TIME_W-1:0] now_secs;
  modport source (output valid, output req_type, output key_index,
                  output requester_node, output now_secs, input ready);
  modport sink   (input valid, input req_type, input key_index,
                  input requester_node, input now_secs, output ready);
endinterface

interface htld_rsp_if import htld_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   entry_index;
  logic [HOT_W-1:0]   hotness_after;
  logic               new_entry;
  logic               migrate_candidate;
  logic [NODE_W-1:0]  dest_node;
  logic [DECAY_W-1:0] decays_done;
  modport source (output valid, output entry_index, output hotness_after,
                  output new_entry, output migrate_candidate,
                  output dest_node, output decays_done, input ready);
  modport sink   (input valid, input entry_index, input hotness_after,
                  input new_entry, input migrate_candidate,
                  input dest_node, input decays_done, output ready);
endinterface

interface htld_cfg_if import htld_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/htld_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module htld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/hotness_table_lazy_decay.sv
// Top level of the hotness table with lazy decay and sweep-based stability decay.
//
//   channel | dir | handshake         | carries
//   --------+-----+-------------------+------------------------------------------
//   req     | in  | valid/ready       | req_type, key_index, requester_node, now_secs
//   rsp     | out | valid/ready       | entry_index, hotness_after, new_entry,
//           |     |                   | migrate_candidate, dest_node, decays_done
//   cfg     | in  | valid/ready (=1)  | index, data
//
// For an access, the accept cycle issues the table read and the next cycle
// modifies the entry and writes it back. A sweep handles one entry per cycle.
// After reset a clearing pass writes every entry invalid, during which no item
// is accepted; configuration writes are always taken. A finished result waits
// in the output register and a second in a spare register; unclaimed results
// hold off new items only once the spare is full.
`default_nettype none

module hotness_table_lazy_decay import htld_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  htld_req_if.sink   req,
  htld_rsp_if.source rsp,
  htld_cfg_if.sink   cfg
);

  // Configuration registers.
  logic [HOT_W-1:0]  mig_level;
  logic [TIME_W-1:0] idle_decay_secs;
  logic [STAB_W-1:0] stability_limit;
  logic [TIME_W-1:0] lazy_step1_secs;
  logic [TIME_W-1:0] lazy_step2_secs;
  logic [TIME_W-1:0] lazy_step3_secs;
  logic [TIME_W-1:0] lazy_step4_secs;

  // Control.
  state_t state;
  state_t state_next;
  logic [IDX_W-1:0]   ptr;
  logic [DECAY_W-1:0] decays;
  logic               ptr_last;
  logic               accept;
  logic               done;

  // The item being worked on.
  logic [IDX_W-1:0]  item_idx;
  logic [NODE_W-1:0] item_node;
  logic [TIME_W-1:0] item_now;

  // Table RAM.
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  entry_t                    ram_wdata;
  logic                      ram_re;
  logic [IDX_W-1:0]          ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                    rd;

  // Results.
  entry_t            acc_word;
  rsp_t              acc_rsp;
  entry_t            sw_word;
  logic              sw_dec;
  rsp_t              res;
  rsp_t              out_q;
  logic              out_valid;
  rsp_t              pend_q;
  logic              pend_valid;
  logic              out_free;

  htld_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd       = entry_t'(ram_rdata);
  assign ptr_last = (ptr == IDX_W'(TABLE_DEPTH - 1));
  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  // Configuration writes; indexes beyond the list are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mig_level         <= HOT_W'(5);
      idle_decay_secs   <= TIME_W'(60);
      stability_limit   <= STAB_W'(3);
      lazy_step1_secs   <= TIME_W'(10);
      lazy_step2_secs   <= TIME_W'(60);
      lazy_step3_secs   <= TIME_W'(300);
      lazy_step4_secs   <= TIME_W'(1800);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_MIG_LEVEL:         mig_level         <= cfg.data[HOT_W-1:0];
        CFG_IDLE_DECAY_SECS:   idle_decay_secs   <= cfg.data[TIME_W-1:0];
        CFG_STABILITY_LIMIT:   stability_limit   <= cfg.data[STAB_W-1:0];
        CFG_LAZY_STEP1_SECS:   lazy_step1_secs   <= cfg.data[TIME_W-1:0];
        CFG_LAZY_STEP2_SECS:   lazy_step2_secs   <= cfg.data[TIME_W-1:0];
        CFG_LAZY_STEP3_SECS:   lazy_step3_secs   <= cfg.data[TIME_W-1:0];
        CFG_LAZY_STEP4_SECS:   lazy_step4_secs   <= cfg.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Access: lazy decay by idle time, saturating increment, migrate check.
  // An entry that is not yet valid is created with hotness one.
  always_comb begin
    logic [TIME_W-1:0] idle;
    logic [HOT_W-1:0]  dec;
    logic [HOT_W-1:0]  hot;
    idle     = item_now - rd.last_seen;
    hot      = rd.hotness;
    acc_word = rd;
    acc_rsp  = '0;
    acc_rsp.entry_index = KEY_W'(item_idx);
    priority if (idle < lazy_step1_secs) begin
      dec = HOT_W'(0);
    end else if (idle < lazy_step2_secs) begin
      dec = HOT_W'(1);
    end else if (idle < lazy_step3_secs) begin
      dec = HOT_W'(2);
    end else if (idle < lazy_step4_secs) begin
      dec = HOT_W'(3);
    end else begin
      dec = HEAT_CEIL;
    end
    if (!rd.valid) begin
      acc_word.valid     = 1'b1;
      acc_word.hotness   = HOT_W'(1);
      acc_word.stability = '0;
      acc_word.last_seen = item_now;
      acc_word.hits      = HITS_W'(1);
      acc_word.home_node = item_node;
      acc_word.preferred = NO_PREFERRED;
      acc_rsp.hotness_after = HOT_W'(1);
      acc_rsp.new_entry     = 1'b1;
    end else begin
      hot = (dec >= rd.hotness) ? '0 : rd.hotness - dec;
      acc_rsp.decays_done = DECAY_W'(hot != rd.hotness);
      if (hot < HEAT_CEIL) begin
        hot = hot + HOT_W'(1);
      end
      if (rd.hits != HITS_FULL) begin
        acc_word.hits = rd.hits + HITS_W'(1);
      end
      acc_word.last_seen = item_now;
      acc_word.hotness   = hot;
      acc_word.stability = '0;
      acc_rsp.hotness_after = hot;
      if (rd.home_node != item_node) begin
        acc_word.preferred        = PREF_W'(item_node);
        acc_rsp.dest_node         = item_node;
        acc_rsp.migrate_candidate = (hot >= mig_level);
      end
    end
  end

  // Sweep, one entry: an idle entry counts up its stability, and once the count
  // passes the limit it loses one hotness step and the count starts over.
  always_comb begin
    logic [TIME_W-1:0] idle;
    logic [STAB_W-1:0] st;
    idle    = item_now - rd.last_seen;
    st      = rd.stability + STAB_W'(1);
    sw_word = rd;
    sw_dec  = 1'b0;
    if (idle > idle_decay_secs) begin
      if (st > stability_limit) begin
        if (rd.hotness > HOTNESS_MIN) begin
          sw_word.hotness = rd.hotness - HOT_W'(1);
          sw_dec          = 1'b1;
        end
        st = '0;
      end
      sw_word.stability = st;
    end else begin
      sw_word.stability = '0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (ptr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = (req.req_type == REQ_SWEEP) ? ST_SWEEP : ST_ACCESS;
      end
      ST_ACCESS: begin
        state_next = ST_IDLE;
      end
      ST_SWEEP: begin
        if (ptr_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: table port controls, input ready and completion.
  always_comb begin
    req.ready = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = '0;
    done      = 1'b0;
    res       = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        req.ready = !pend_valid;
        ram_re    = accept;
        ram_raddr = (req.req_type == REQ_SWEEP) ? '0 : IDX_W'(req.key_index);
      end
      ST_ACCESS: begin
        ram_we    = 1'b1;
        ram_waddr = item_idx;
        ram_wdata = acc_word;
        done      = 1'b1;
        res       = acc_rsp;
      end
      ST_SWEEP: begin
        // Read the next entry while the current one is written back.
        ram_re    = !ptr_last;
        ram_raddr = ptr + IDX_W'(1);
        ram_we    = rd.valid;
        ram_wdata = sw_word;
        done      = ptr_last;
        res.decays_done = decays + DECAY_W'(sw_dec && rd.valid);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      ptr    <= '0;
      decays <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: ptr <= ptr + IDX_W'(1);
        ST_IDLE: begin
          ptr    <= '0;
          decays <= '0;
        end
        ST_SWEEP: begin
          ptr    <= ptr + IDX_W'(1);
          decays <= decays + DECAY_W'(sw_dec && rd.valid);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_idx  <= IDX_W'(req.key_index);
      item_node <= req.requester_node;
      item_now  <= req.now_secs;
    end
  end

  // Output register plus one spare slot. A new item is only taken when the spare
  // slot is empty, so a finished result always has a place to go.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (done) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        pend_valid <= 1'b1;
      end
    end else if (pend_valid && out_free) begin
      out_valid  <= 1'b1;
      pend_valid <= 1'b0;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        pend_q <= res;
      end
    end else if (pend_valid && out_free) begin
      out_q <= pend_q;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.entry_index       = out_q.entry_index;
  assign rsp.hotness_after     = out_q.hotness_after;
  assign rsp.new_entry         = out_q.new_entry;
  assign rsp.migrate_candidate = out_q.migrate_candidate;
  assign rsp.dest_node         = out_q.dest_node;
  assign rsp.decays_done       = out_q.decays_done;

endmodule

`default_nettype wire

### tb/hotness_table_lazy_decay_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the hotness table with lazy decay and sweep decay.

module hotness_table_lazy_decay_tb import htld_pkg::*; ();

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 11;
  // Longest quiet stretch of a correct run is the clearing pass plus one sweep
  // plus the longest gaps on both sides; this limit is far beyond it.
  localparam int STALL_LIMIT     = 20000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int REPORT_LIMIT    = 10;
  localparam int SETTLE_CYCLES   = 20;
  localparam int HOT_KEYS        = 16;
  // No register lives at this index, so a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  // Scoreboard with its own model of the table. The hit count and the
  // preferred node never show up in a result, so they are not tracked.
  class hotness_scoreboard;
    bit                row_valid [TABLE_DEPTH];
    logic [HOT_W-1:0]  row_heat  [TABLE_DEPTH];
    logic [STAB_W-1:0] row_stab  [TABLE_DEPTH];
    logic [TIME_W-1:0] row_seen  [TABLE_DEPTH];
    logic [NODE_W-1:0] row_home  [TABLE_DEPTH];
    logic [HOT_W-1:0]  mig_thresh;
    logic [TIME_W-1:0] idle_limit;
    logic [STAB_W-1:0] stab_limit;
    logic [TIME_W-1:0] step_secs [4];
    rsp_t              expected_rsp [$];
    int                mismatches;
    int                unexpected;
    int                reports;

    function new();
      mig_thresh = 8'd5;
      idle_limit = 16'd60;
      stab_limit = 8'd3;
      step_secs  = '{16'd10, 16'd60, 16'd300, 16'd1800};
      foreach (row_valid[i]) row_valid[i] = 1'b0;
      mismatches = 0;
      unexpected = 0;
      reports    = 0;
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIG_LEVEL:         mig_thresh   = data[HOT_W-1:0];
        CFG_IDLE_DECAY_SECS:   idle_limit   = data;
        CFG_STABILITY_LIMIT:   stab_limit   = data[STAB_W-1:0];
        CFG_LAZY_STEP1_SECS:   step_secs[0] = data;
        CFG_LAZY_STEP2_SECS:   step_secs[1] = data;
        CFG_LAZY_STEP3_SECS:   step_secs[2] = data;
        CFG_LAZY_STEP4_SECS:   step_secs[3] = data;
        default: ;
      endcase
    endfunction

    function logic [HOT_W-1:0] lazy_drop(logic [TIME_W-1:0] idle);
      if (idle < step_secs[0]) return '0;
      if (idle < step_secs[1]) return HOT_W'(1);
      if (idle < step_secs[2]) return HOT_W'(2);
      if (idle < step_secs[3]) return HOT_W'(3);
      return HEAT_CEIL;
    endfunction

    function void note_request(req_kind_t kind, logic [KEY_W-1:0] key,
                               logic [NODE_W-1:0] node, logic [TIME_W-1:0] now);
      rsp_t               r;
      logic [TIME_W-1:0]  idle;
      logic [HOT_W-1:0]   drop;
      logic [HOT_W-1:0]   heat;
      logic [HOT_W-1:0]   prior;
      logic [STAB_W-1:0]  st;
      logic [DECAY_W-1:0] lowered;
      r = '0;
      if (kind == REQ_SWEEP) begin
        lowered = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!row_valid[i]) continue;
          idle = now - row_seen[i];
          if (idle > idle_limit) begin
            st = row_stab[i] + 1'b1;
            if (st > stab_limit) begin
              if (row_heat[i] > HOTNESS_MIN) begin
                row_heat[i] = row_heat[i] - 1'b1;
                lowered++;
              end
              st = '0;
            end
            row_stab[i] = st;
          end else begin
            row_stab[i] = '0;
          end
        end
        r.decays_done = lowered;
      end else if (!row_valid[key]) begin
        row_valid[key]  = 1'b1;
        row_heat[key]   = HOT_W'(1);
        row_stab[key]   = '0;
        row_seen[key]   = now;
        row_home[key]   = node;
        r.entry_index   = key;
        r.hotness_after = HOT_W'(1);
        r.new_entry     = 1'b1;
      end else begin
        idle          = now - row_seen[key];
        drop          = lazy_drop(idle);
        row_seen[key] = now;
        prior         = row_heat[key];
        heat          = prior;
        if (drop != '0) begin
          heat = (drop >= prior) ? '0 : prior - drop;
          if (heat != prior) r.decays_done = DECAY_W'(1);
        end
        if (heat < HEAT_CEIL) heat++;
        row_heat[key] = heat;
        row_stab[key] = '0;
        if (row_home[key] != node) begin
          r.dest_node = node;
          if (heat >= mig_thresh) r.migrate_candidate = 1'b1;
        end
        r.entry_index   = key;
        r.hotness_after = heat;
      end
      expected_rsp.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        unexpected++;
        if (reports < REPORT_LIMIT) begin
          reports++;
          $display({"result with nothing expected: ",
                    "idx %0d hot %0d new %0b mig %0b node %0d dec %0d"},
                   got.entry_index, got.hotness_after, got.new_entry,
                   got.migrate_candidate, got.dest_node, got.decays_done);
        end
        return;
      end
      want = expected_rsp.pop_front();
      if (got.entry_index !== want.entry_index || got.hotness_after !== want.hotness_after ||
          got.new_entry !== want.new_entry || got.migrate_candidate !== want.migrate_candidate ||
          got.dest_node !== want.dest_node || got.decays_done !== want.decays_done) begin
        mismatches++;
        if (reports < REPORT_LIMIT) begin
          reports++;
          $display("mismatch: expected idx %0d hot %0d new %0b mig %0b node %0d dec %0d",
                   want.entry_index, want.hotness_after, want.new_entry,
                   want.migrate_candidate, want.dest_node, want.decays_done);
          $display("          actual   idx %0d hot %0d new %0b mig %0b node %0d dec %0d",
                   got.entry_index, got.hotness_after, got.new_entry,
                   got.migrate_candidate, got.dest_node, got.decays_done);
        end
      end
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    function int failures();
      return mismatches + unexpected + expected_rsp.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  htld_req_if req_ch();
  htld_rsp_if rsp_ch();
  htld_cfg_if cfg_ch();

  hotness_table_lazy_decay i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  hotness_scoreboard     sb;
  int                    idle_cycles;
  // When set, the sender and the receiver draw random gaps; both are toggled
  // in stretches so that long runs at full rate occur as well.
  bit                    sender_gaps = 1'b1;
  bit                    sink_stalls = 1'b1;
  // Running time base; each access idles its entry by however far this moved
  // since the entry was last touched.
  logic [TIME_W-1:0]     wall;
  logic [KEY_W-1:0]      hot_keys [HOT_KEYS];
  logic [CFG_DATA_W-1:0] reg_vals [7];

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int draw_gap();
    return sender_gaps ? int'($urandom_range(0, 5)) : 0;
  endfunction

  // Presents one item at a falling edge and holds it until it is taken. The
  // valid stays high afterward so that back-to-back items need no dip; any
  // caller that waits for something else lowers it first.
  task automatic send_request(req_kind_t kind, logic [KEY_W-1:0] key,
                              logic [NODE_W-1:0] node, logic [TIME_W-1:0] now, int gap);
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.req_type       = kind;
    req_ch.key_index      = key;
    req_ch.requester_node = node;
    req_ch.now_secs       = now;
    req_ch.valid          = 1'b1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(kind, key, node, now);
  endtask

  // Stops sending and waits until every expected result has been taken.
  task automatic drain_results();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.apply_register(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Picks the register values of one phase: reset values, all zero, all ones,
  // two ordered random sets and one random set with a small migrate level and
  // stability limit, whose unused upper bits on byte-wide registers are random.
  task automatic choose_settings(int phase);
    logic [TIME_W-1:0] edge1;
    logic [TIME_W-1:0] edge2;
    logic [TIME_W-1:0] edge3;
    case (phase)
      0: reg_vals = '{16'd5, 16'd60, 16'd3, 16'd10, 16'd60, 16'd300, 16'd1800};
      1: reg_vals = '{default: '0};
      2: reg_vals = '{default: '1};
      3, 4: begin
        edge1 = TIME_W'($urandom_range(0, 40));
        edge2 = edge1 + TIME_W'($urandom_range(0, 150));
        edge3 = edge2 + TIME_W'($urandom_range(0, 600));
        reg_vals[CFG_MIG_LEVEL]         = CFG_DATA_W'($urandom_range(0, 16));
        reg_vals[CFG_IDLE_DECAY_SECS]   = CFG_DATA_W'($urandom_range(0, 300));
        reg_vals[CFG_STABILITY_LIMIT]   = CFG_DATA_W'($urandom_range(0, 4));
        reg_vals[CFG_LAZY_STEP1_SECS]   = edge1;
        reg_vals[CFG_LAZY_STEP2_SECS]   = edge2;
        reg_vals[CFG_LAZY_STEP3_SECS]   = edge3;
        reg_vals[CFG_LAZY_STEP4_SECS]   = edge3 + TIME_W'($urandom_range(0, 3000));
      end
      default: begin
        foreach (reg_vals[i]) reg_vals[i] = CFG_DATA_W'($urandom);
        reg_vals[CFG_MIG_LEVEL][7:0]       = 8'($urandom_range(0, 15));
        reg_vals[CFG_STABILITY_LIMIT][7:0] = 8'($urandom_range(0, 3));
      end
    endcase
  endtask

  // Opening items under the reset settings: creation, local and remote hits up
  // to the migrate threshold, every lazy decay step including the full clear,
  // a decay down to zero across a wrap of the time base, both ends of the key
  // range, and a run of sweeps that walks hotness down to the floor and then
  // one that clears the stability count of a freshly touched entry.
  task automatic directed_items();
    send_request(REQ_SWEEP,  10'd0,    3'd0, 16'd0,     draw_gap());
    send_request(REQ_ACCESS, 10'd0,    3'd0, 16'd0,     draw_gap());
    send_request(REQ_ACCESS, 10'd0,    3'd0, 16'd5,     draw_gap());
    send_request(REQ_ACCESS, 10'd0,    3'd3, 16'd6,     draw_gap());
    send_request(REQ_ACCESS, 10'd0,    3'd3, 16'd7,     draw_gap());
    send_request(REQ_ACCESS, 10'd0,    3'd3, 16'd8,     draw_gap());
    send_request(REQ_ACCESS, 10'd0,    3'd0, 16'd20,    draw_gap());
    send_request(REQ_ACCESS, 10'd0,    3'd0, 16'd100,   draw_gap());
    send_request(REQ_ACCESS, 10'd0,    3'd0, 16'd500,   draw_gap());
    send_request(REQ_ACCESS, 10'd0,    3'd0, 16'd3000,  draw_gap());
    send_request(REQ_ACCESS, 10'd1023, 3'd7, 16'd65530, draw_gap());
    send_request(REQ_ACCESS, 10'd1023, 3'd7, 16'd4,     draw_gap());
    send_request(REQ_ACCESS, 10'd1023, 3'd0, 16'd4,     draw_gap());
    send_request(REQ_ACCESS, 10'd512,  3'd5, 16'd4,     draw_gap());
    repeat (8) send_request(REQ_SWEEP, 10'd1023, 3'd7, 16'd200, draw_gap());
    send_request(REQ_ACCESS, 10'd0,    3'd1, 16'd205,   draw_gap());
    send_request(REQ_SWEEP,  10'd0,    3'd0, 16'd210,   draw_gap());
  endtask

  // Random traffic: mostly accesses to a small set of keys so entries are hit
  // again and again, with the time base moving in steps that land in every
  // lazy decay band, occasional fully random keys, and short bursts of sweeps
  // so that stability counts climb past their limit.
  task automatic run_random_phase(int count);
    int                sweeps_left;
    int                band;
    req_kind_t         kind;
    logic [KEY_W-1:0]  key;
    logic [NODE_W-1:0] node;
    sweeps_left = 0;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        sender_gaps = ($urandom_range(0, 2) != 0);
        sink_stalls = ($urandom_range(0, 2) != 0);
      end
      // Now and then hold off until the block has handed back everything.
      if ($urandom_range(0, 49) == 0) drain_results();
      if (sweeps_left > 0) begin
        kind = REQ_SWEEP;
        sweeps_left--;
      end else if ($urandom_range(0, 99) < 3) begin
        kind        = REQ_SWEEP;
        sweeps_left = $urandom_range(0, 4);
      end else begin
        kind = REQ_ACCESS;
      end
      band = $urandom_range(0, 9);
      if (band < 4)      wall = wall + TIME_W'($urandom_range(0, 3));
      else if (band < 7) wall = wall + TIME_W'($urandom_range(0, 80));
      else if (band < 9) wall = wall + TIME_W'($urandom_range(0, 700));
      else               wall = wall + TIME_W'($urandom);
      key  = ($urandom_range(0, 99) < 85) ? hot_keys[$urandom_range(0, HOT_KEYS - 1)]
                                          : KEY_W'($urandom);
      node = ($urandom_range(0, 1) != 0) ? key[NODE_W-1:0] : NODE_W'($urandom);
      send_request(kind, key, node, wall, draw_gap());
    end
  endtask

  // Receiver: per result a random number of cycles with ready low, then ready
  // high until a result is taken, which is then checked.
  initial begin
    int   stall;
    rsp_t got;
    rsp_ch.ready = 1'b0;
    forever begin
      stall = sink_stalls ? int'($urandom_range(0, 5)) : 0;
      if (stall > 0) begin
        @(negedge clk);
        rsp_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (rst || rsp_ch.valid !== 1'b1);
      got.entry_index       = rsp_ch.entry_index;
      got.hotness_after     = rsp_ch.hotness_after;
      got.new_entry         = rsp_ch.new_entry;
      got.migrate_candidate = rsp_ch.migrate_candidate;
      got.dest_node         = rsp_ch.dest_node;
      got.decays_done       = rsp_ch.decays_done;
      sb.check_response(got);
    end
  end

  // Watchdog: ends the run when no channel has moved an item for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("hotness_table_lazy_decay_tb NOT OK");
    $finish;
  end

  initial begin
    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.req_type       = REQ_ACCESS;
    req_ch.key_index      = '0;
    req_ch.requester_node = '0;
    req_ch.now_secs       = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = CFG_MIG_LEVEL;
    cfg_ch.data           = '0;
    wall                  = '0;
    sb                    = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The configuration port is open during the clearing pass, so a write to
    // the empty index can go in right away; it must leave the settings alone.
    program_register(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
    directed_items();

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      choose_settings(phase);
      foreach (reg_vals[i]) program_register(CFG_IDX_W'(i), reg_vals[i]);
      program_register(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
      hot_keys[0] = '0;
      hot_keys[1] = '1;
      for (int k = 2; k < HOT_KEYS; k++) hot_keys[k] = KEY_W'($urandom);
      run_random_phase(ITEMS_PER_PHASE);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures() == 0)
      $display("hotness_table_lazy_decay_tb OK");
    else
      $display("hotness_table_lazy_decay_tb NOT OK");
    $finish;
  end

endmodule
